// ===== hdl/utd_pkg.sv =====
package utd_pkg;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Code  = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Code  = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Code  = 8'hF0;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = QueuePtrW + 1;

  // one result word
  typedef struct packed {
    logic [6:0] out_char;
    logic       has_char;
    logic       end_of_text;
  } res_t;

  // results of one input byte, handed to the result queue
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] base;
  } lookup_t;

  // 1 for ASCII, 2..4 for a lead byte, 0 for a stray byte
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    if (b < AsciiLimit) n = 3'd1;
    else if ((b & Lead2Mask) == Lead2Code) n = 3'd2;
    else if ((b & Lead3Mask) == Lead3Code) n = 3'd3;
    else if ((b & Lead4Mask) == Lead4Code) n = 3'd4;
    else n = 3'd0;
    return n;
  endfunction

  // accented Czech letters and their base letter
  function automatic lookup_t letter_lookup(input logic [7:0] lead, input logic [7:0] trail);
    lookup_t r;
    r.hit = 1'b1;
    case ({lead, trail})
      16'hC381: r.base = 7'(8'h41);  // A
      16'hC3A1: r.base = 7'(8'h61);  // a
      16'hC48C: r.base = 7'(8'h43);  // C
      16'hC48D: r.base = 7'(8'h63);  // c
      16'hC48E: r.base = 7'(8'h44);  // D
      16'hC48F: r.base = 7'(8'h64);  // d
      16'hC389: r.base = 7'(8'h45);  // E
      16'hC3A9: r.base = 7'(8'h65);  // e
      16'hC49A: r.base = 7'(8'h45);  // E
      16'hC49B: r.base = 7'(8'h65);  // e
      16'hC38D: r.base = 7'(8'h49);  // I
      16'hC3AD: r.base = 7'(8'h69);  // i
      16'hC587: r.base = 7'(8'h4E);  // N
      16'hC588: r.base = 7'(8'h6E);  // n
      16'hC393: r.base = 7'(8'h4F);  // O
      16'hC3B3: r.base = 7'(8'h6F);  // o
      16'hC598: r.base = 7'(8'h52);  // R
      16'hC599: r.base = 7'(8'h72);  // r
      16'hC5A0: r.base = 7'(8'h53);  // S
      16'hC5A1: r.base = 7'(8'h73);  // s
      16'hC5A4: r.base = 7'(8'h54);  // T
      16'hC5A5: r.base = 7'(8'h74);  // t
      16'hC39A: r.base = 7'(8'h55);  // U
      16'hC3BA: r.base = 7'(8'h75);  // u
      16'hC5AE: r.base = 7'(8'h55);  // U
      16'hC5AF: r.base = 7'(8'h75);  // u
      16'hC39D: r.base = 7'(8'h59);  // Y
      16'hC3BD: r.base = 7'(8'h79);  // y
      16'hC5BD: r.base = 7'(8'h5A);  // Z
      16'hC5BE: r.base = 7'(8'h7A);  // z
      default: begin
        r.hit  = 1'b0;
        r.base = 7'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/utf8_diacritic_stripper.sv =====
// UTF-8 to plain ASCII stripper for a character display.
// Slave stream: one text byte per word, tlast on the final byte of the text.
// Master stream: one result per word; tuser says whether tdata carries a
// character, tlast marks the final result of the text. A final byte that
// yields no character still gives one word with tuser low and tlast high.
// Accented Czech letters become their base letter, other multi-byte
// sequences and stray bytes give no word.
// An accepted byte passes the input register, then is decoded into a
// 4-word result queue. Throughput: one byte per cycle while the queue
// has room. A byte gives 0, 1 or 2 words; the master side moves one word
// per cycle, so the rate is set by the queue drain. When the receiver
// stalls the queue fills; the input register stops taking bytes once
// fewer than two queue entries are free. Reset empties the input
// register and the queue and drops any partially received sequence, so
// the next byte starts a new text.
module utf8_diacritic_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic [0:0] m_axis_tuser,   // [0] has_char
  output logic       m_axis_tlast    // end_of_text
);

  logic           in_valid_q, in_valid_d;
  logic [7:0]     in_byte_q;
  logic           in_last_q;
  logic           room, advance, accept;
  utd_pkg::push_t push;
  utd_pkg::res_t  res;

  assign advance       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  utd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  utd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res.out_char};
  assign m_axis_tuser = res.has_char;
  assign m_axis_tlast = res.end_of_text;

  // an empty result only ever closes a text
  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("result without character is not end of text");

  // the queue only takes words while it has room for a full item
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.num != 2'd0 |-> room)
    else $error("result queue overrun");

  // a held input byte waits unchanged until it is decoded
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("input byte lost while queue full");

  // a final byte always produces at least one word
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |-> push.num != 2'd0)
    else $error("final byte produced no result");

endmodule

// ===== hdl/utd_decode.sv =====
module utd_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,   // consume the byte below this cycle
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output utd_pkg::push_t push_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] lead_q, lead_d;   // first held byte
  logic [7:0] next_q, next_d;   // second held byte, only read for a cut-off 4-byte lead

  logic [1:0] nc;
  logic [6:0] c0, c1;

  always_comb begin
    utd_pkg::lookup_t lk;
    logic [2:0]       n;
    logic             done;
    nc     = 2'd0;
    c0     = byte_i[6:0];
    c1     = byte_i[6:0];
    cnt_d  = cnt_q;
    lead_d = lead_q;
    next_d = next_q;
    lk     = utd_pkg::letter_lookup(lead_q, byte_i);
    n      = utd_pkg::seq_len(lead_q);
    done   = ({1'b0, cnt_q} + 3'd1 >= n) || (cnt_q == 2'd3);
    if (cnt_q == 2'd0) begin
      if (utd_pkg::seq_len(byte_i) == 3'd1) begin
        nc = 2'd1;
      end else if (!last_i && utd_pkg::seq_len(byte_i) >= 3'd2) begin
        lead_d = byte_i;
        cnt_d  = 2'd1;
      end
    end else if (done) begin
      if (n == 3'd2 && lk.hit) begin
        nc = 2'd1;
        c0 = lk.base;
      end
      cnt_d = 2'd0;
    end else if (last_i) begin
      // cut off: lead dropped, rest replayed
      cnt_d = 2'd0;
      if (cnt_q == 2'd1) begin
        if (utd_pkg::seq_len(byte_i) == 3'd1) nc = 2'd1;
      end else begin
        lk = utd_pkg::letter_lookup(next_q, byte_i);
        if (utd_pkg::seq_len(next_q) == 3'd1) begin
          c0 = next_q[6:0];
          nc = (utd_pkg::seq_len(byte_i) == 3'd1) ? 2'd2 : 2'd1;
        end else if (utd_pkg::seq_len(next_q) == 3'd2) begin
          c0 = lk.base;
          nc = lk.hit ? 2'd1 : 2'd0;
        end else if (utd_pkg::seq_len(byte_i) == 3'd1) begin
          nc = 2'd1;
        end
      end
    end else begin
      if (cnt_q == 2'd1) next_d = byte_i;
      cnt_d = cnt_q + 2'd1;
    end
  end

  always_comb begin
    push_o.r0.out_char    = c0;
    push_o.r0.has_char    = 1'b1;
    push_o.r0.end_of_text = last_i && (nc == 2'd1);
    push_o.r1.out_char    = c1;
    push_o.r1.has_char    = 1'b1;
    push_o.r1.end_of_text = last_i;
    push_o.num            = step_i ? nc : 2'd0;
    if (last_i && nc == 2'd0) begin
      push_o.r0.out_char    = 7'd0;
      push_o.r0.has_char    = 1'b0;
      push_o.r0.end_of_text = 1'b1;
      push_o.num            = step_i ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      lead_q <= lead_d;
      next_q <= next_d;
    end
  end

endmodule

// ===== hdl/utd_outq.sv =====
module utd_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  utd_pkg::push_t push_i,
  output logic           room_o,   // space for two more words
  output logic           valid_o,
  input  logic           ready_i,
  output utd_pkg::res_t  res_o
);

  utd_pkg::res_t                   mem_q [utd_pkg::QueueDepth];
  logic [utd_pkg::QueuePtrW-1:0]   rd_q, wr_q;
  logic [utd_pkg::QueueCntW-1:0]   cnt_q, cnt_d;
  logic                            pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign room_o  = cnt_q <= utd_pkg::QueueCntW'(utd_pkg::QueueDepth - 2);
  assign res_o   = mem_q[rd_q];
  assign cnt_d   = cnt_q + utd_pkg::QueueCntW'(push_i.num) - utd_pkg::QueueCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_q + utd_pkg::QueuePtrW'(pop);
      wr_q  <= wr_q + utd_pkg::QueuePtrW'(push_i.num);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.num == 2'd2) mem_q[wr_q + utd_pkg::QueuePtrW'(1)] <= push_i.r1;
  end

endmodule

// ===== tb/sv/tb_text_pkg.sv =====
package tb_text_pkg;

  // {lead, trail, base letter} of every accented letter that maps to ASCII
  localparam int unsigned NumLetters = 30;
  localparam logic [23:0] LetterTab [NumLetters] = '{
    24'hC381_41, 24'hC3A1_61, 24'hC48C_43, 24'hC48D_63, 24'hC48E_44,
    24'hC48F_64, 24'hC389_45, 24'hC3A9_65, 24'hC49A_45, 24'hC49B_65,
    24'hC38D_49, 24'hC3AD_69, 24'hC587_4E, 24'hC588_6E, 24'hC393_4F,
    24'hC3B3_6F, 24'hC598_52, 24'hC599_72, 24'hC5A0_53, 24'hC5A1_73,
    24'hC5A4_54, 24'hC5A5_74, 24'hC39A_55, 24'hC3BA_75, 24'hC5AE_55,
    24'hC5AF_75, 24'hC39D_59, 24'hC3BD_79, 24'hC5BD_5A, 24'hC5BE_7A
  };

  class text_scoreboard;
    utd_pkg::res_t expected_q[$];
    logic [6:0]    found_q[$];
    logic [7:0]    tail_q[$];
    logic [7:0]    held [3];
    int unsigned   held_cnt;
    int unsigned   errors;

    function new();
      held_cnt = 0;
      errors   = 0;
    endfunction

    // 1 = ASCII, 2..4 = lead of that length, 0 = stray
    function int unsigned code_len(logic [7:0] b);
      casez (b)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        default:     return 0;
      endcase
    endfunction

    function void find_letter(logic [7:0] lead, logic [7:0] trail);
      foreach (LetterTab[k]) begin
        if (LetterTab[k][23:8] == {lead, trail}) begin
          found_q.push_back(LetterTab[k][6:0]);
          return;
        end
      end
    endfunction

    // bytes left at the end of a text, decoded again from their start
    function void decode_tail();
      int unsigned i;
      int unsigned n;
      i = 0;
      while (i < tail_q.size()) begin
        n = code_len(tail_q[i]);
        if (n == 1) begin
          found_q.push_back(tail_q[i][6:0]);
          i++;
        end else if (n >= 2 && i + n - 1 < tail_q.size()) begin
          if (n == 2) find_letter(tail_q[i], tail_q[i + 1]);
          i += n;
        end else begin
          i++;
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic lst);
      int unsigned   n;
      utd_pkg::res_t r;
      found_q.delete();
      tail_q.delete();
      if (held_cnt == 0) begin
        n = code_len(b);
        if (lst) begin
          tail_q.push_back(b);
          decode_tail();
        end else if (n == 1) begin
          found_q.push_back(b[6:0]);
        end else if (n >= 2) begin
          held[0]  = b;
          held_cnt = 1;
        end
      end else begin
        n = code_len(held[0]);
        if (n < 2) n = 2;
        if (held_cnt + 1 >= n || held_cnt >= 3) begin
          if (n == 2) find_letter(held[0], b);
          held_cnt = 0;
        end else if (lst) begin
          // cut-off sequence: drop the lead, replay the rest
          for (int j = 1; j < held_cnt; j++) tail_q.push_back(held[j]);
          tail_q.push_back(b);
          decode_tail();
          held_cnt = 0;
        end else begin
          held[held_cnt] = b;
          held_cnt++;
        end
      end
      while (found_q.size() > 2) void'(found_q.pop_back());
      if (lst && found_q.size() == 0) begin
        r.out_char    = '0;
        r.has_char    = 1'b0;
        r.end_of_text = 1'b1;
        expected_q.push_back(r);
      end else begin
        foreach (found_q[k]) begin
          r.out_char    = found_q[k];
          r.has_char    = 1'b1;
          r.end_of_text = lst && (k == found_q.size() - 1);
          expected_q.push_back(r);
        end
      end
    endfunction

    function void check_word(logic [7:0] data, logic [0:0] user, logic lst);
      utd_pkg::res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word data=%h user=%b last=%b", $time, data, user, lst);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data[6:0] !== e.out_char) begin
        $display("%0t: out_char expected %h actual %h", $time, e.out_char, data[6:0]);
        errors++;
      end
      if (data[7] !== 1'b0) begin
        $display("%0t: tdata[7] expected 0 actual %b", $time, data[7]);
        errors++;
      end
      if (user[0] !== e.has_char) begin
        $display("%0t: has_char expected %b actual %b", $time, e.has_char, user[0]);
        errors++;
      end
      if (lst !== e.end_of_text) begin
        $display("%0t: end_of_text expected %b actual %b", $time, e.end_of_text, lst);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void report_leftover();
      if (expected_q.size() != 0) begin
        $display("%0t: %0d words never arrived, first expected %h", $time,
                 expected_q.size(), expected_q[0]);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TotalBytes    = 1125;
  localparam int unsigned HoldOffAt     = 250;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned QuietFrom     = 500;
  localparam int unsigned QuietTo       = 700;
  localparam int unsigned DrainAt       = 850;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic       m_axis_tlast;

  tb_text_pkg::text_scoreboard sb;
  logic [7:0]                  text_q[$];
  int unsigned                 bytes_sent;
  int unsigned                 hold_left;
  bit                          no_idle;
  bit                          drained;

  utf8_diacritic_stripper u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // receiver: random stalls, always ready while no_idle is set, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 28);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!no_idle && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, lst);
    bytes_sent++;
    if (bytes_sent == HoldOffAt) hold_left = HoldOffCycles;
    no_idle = (bytes_sent >= QuietFrom && bytes_sent < QuietTo);
    @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic void add_letter();
    int unsigned k;
    k = $urandom_range(tb_text_pkg::NumLetters - 1);
    text_q.push_back(tb_text_pkg::LetterTab[k][23:16]);
    text_q.push_back(tb_text_pkg::LetterTab[k][15:8]);
  endfunction

  function automatic void add_piece();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 38) begin
      text_q.push_back(8'($urandom_range(127)));
    end else if (pick < 63) begin
      add_letter();
    end else if (pick < 70) begin
      text_q.push_back(8'hC0 | 8'($urandom_range(31)));
      text_q.push_back(8'($urandom_range(255)));
    end else if (pick < 78) begin
      text_q.push_back(8'hE0 | 8'($urandom_range(15)));
      text_q.push_back(cont_byte());
      text_q.push_back(cont_byte());
    end else if (pick < 84) begin
      text_q.push_back(8'hF0 | 8'($urandom_range(7)));
      repeat (3) text_q.push_back(cont_byte());
    end else begin
      text_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic logic [7:0] loose_byte();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(127));
      1:       return 8'hC3 + 8'($urandom_range(2));
      2:       return tb_text_pkg::LetterTab[$urandom_range(tb_text_pkg::NumLetters - 1)][15:8];
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // text ends inside a multi-byte sequence
  function automatic void add_cut_end();
    case ($urandom_range(2))
      0: text_q.push_back(8'hC0 | 8'($urandom_range(31)));
      1: begin
        text_q.push_back(8'hE0 | 8'($urandom_range(15)));
        if ($urandom_range(1)) text_q.push_back(loose_byte());
      end
      default: begin
        text_q.push_back(8'hF0 | 8'($urandom_range(7)));
        if ($urandom_range(2) == 0) add_letter();
        else repeat ($urandom_range(2)) text_q.push_back(loose_byte());
      end
    endcase
  endfunction

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    bytes_sent    = 0;
    hold_left     = 0;
    no_idle       = 1'b0;
    drained       = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ASCII extremes, table hits, pair miss eating ASCII, 3-byte drop, strays
    text_q = '{8'h41, 8'h00, 8'h7F, 8'hC3, 8'h81, 8'hC5, 8'hBE, 8'hC3, 8'h41,
               8'hE2, 8'h82, 8'hAC, 8'h80, 8'hFF, 8'h5A};
    send_text();
    // lone lead at the end: empty end word
    text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC3};
    send_text();
    // three-byte lead completed by two ASCII bytes: all dropped, empty end word
    text_q = '{8'hE2, 8'h41, 8'h42};
    send_text();
    // cut-off four-byte lead, held pair replayed as a letter
    text_q = '{8'hF0, 8'hC3, 8'hA1};
    send_text();

    while (bytes_sent < TotalBytes) begin
      text_q.delete();
      repeat ($urandom_range(1, 12)) add_piece();
      if ($urandom_range(99) < 35) add_cut_end();
      send_text();
      if (!drained && bytes_sent >= DrainAt) begin
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (sb.pending() != 0);
        drained = 1'b1;
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (20) @(negedge clk_i);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
